>>> hw/rtl/tps_pkg.sv
// Package for the triangle plane slicer: widths, register indexes and helpers.
// Used by triangle_plane_slicer_top; depends on nothing else.
`default_nettype none
package tps_pkg;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned DEPTH_W = 66;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DEPTH_W-1:0] depth_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_X  = 3'd0,
		REG_ROW_Y  = 3'd1,
		REG_ROW_Z  = 3'd2,
		REG_OFFSET = 3'd3,
		REG_CLIP   = 3'd4
	} cfg_reg_t;

	// Magnitude of a signed depth difference.
	function automatic logic [DEPTH_W-1:0] mag(input depth_t v);
		mag = v[DEPTH_W-1] ? DEPTH_W'(-v) : DEPTH_W'(v);
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/triangle_plane_slicer_top.sv
// Top level of the triangle plane slicer: depth, classification, pipelined
// ratio divider and interpolation. Depends on tps_pkg.
//
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             a_x..c_z, last_triangle
// result    out        done (one cycle)          hit, p0_*, p1_*, last_segment
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One request enters every cycle; busy is tied low.
// The divider produces one quotient bit a stage.
// Reset clears the valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module triangle_plane_slicer_top #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire tps_pkg::coord_t             a_x,
	input  wire tps_pkg::coord_t             a_y,
	input  wire tps_pkg::coord_t             a_z,
	input  wire tps_pkg::coord_t             b_x,
	input  wire tps_pkg::coord_t             b_y,
	input  wire tps_pkg::coord_t             b_z,
	input  wire tps_pkg::coord_t             c_x,
	input  wire tps_pkg::coord_t             c_y,
	input  wire tps_pkg::coord_t             c_z,
	input  wire logic                        last_triangle,
	output logic                             done,
	output logic                             hit,
	output tps_pkg::coord_t                  p0_x,
	output tps_pkg::coord_t                  p0_y,
	output tps_pkg::coord_t                  p0_z,
	output tps_pkg::coord_t                  p1_x,
	output tps_pkg::coord_t                  p1_y,
	output tps_pkg::coord_t                  p1_z,
	output logic                             last_segment,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire tps_pkg::coord_t             cfg_data
);
	import tps_pkg::*;

	localparam int unsigned DW = DEPTH_W;
	localparam int unsigned DLW = COORD_W + 1;
	localparam int unsigned QW = FRAC_BITS + 1;
	localparam int unsigned PW = DLW + QW + 1;
	localparam int unsigned LAT = FRAC_BITS + 5;

	typedef struct packed {
		logic                      hit;
		logic                      last;
		logic                      full0;
		logic                      full1;
		logic [2:0][COORD_W-1:0]   ai;
		logic [2:0][DLW-1:0]       dl0;
		logic [2:0][DLW-1:0]       dl1;
	} pay_t;

	// The pipeline never stalls.
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	coord_t row_x_q, row_y_q, row_z_q, offset_q, clip_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= '0;
			row_y_q  <= '0;
			row_z_q  <= coord_t'(64'd1 << FRAC_BITS);
			offset_q <= '0;
			clip_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_X:  row_x_q  <= cfg_data;
				REG_ROW_Y:  row_y_q  <= cfg_data;
				REG_ROW_Z:  row_z_q  <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data;
				REG_CLIP:   clip_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: capture the request.
	logic vld_s1, last_s1;
	coord_t v_s1 [3][3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start && !busy;
	end
	always_ff @(posedge clk) begin
		v_s1[0][0] <= a_x; v_s1[0][1] <= a_y; v_s1[0][2] <= a_z;
		v_s1[1][0] <= b_x; v_s1[1][1] <= b_y; v_s1[1][2] <= b_z;
		v_s1[2][0] <= c_x; v_s1[2][1] <= c_y; v_s1[2][2] <= c_z;
		last_s1 <= last_triangle;
	end

	// Stage 2: nine products of coordinates and row weights.
	logic vld_s2, last_s2;
	coord_t v_s2 [3][3];
	logic signed [2*COORD_W-1:0] prod_s2 [3][3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s2[k][0] <= row_x_q * v_s1[k][0];
			prod_s2[k][1] <= row_y_q * v_s1[k][1];
			prod_s2[k][2] <= row_z_q * v_s1[k][2];
		end
		v_s2 <= v_s1;
		last_s2 <= last_s1;
	end

	// Stage 3: depth of each vertex, floored products plus offset.
	logic vld_s3, last_s3;
	coord_t v_s3 [3][3];
	depth_t dep_s3 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			dep_s3[k] <= DW'(prod_s2[k][0] >>> FRAC_BITS) + DW'(prod_s2[k][1] >>> FRAC_BITS)
				+ DW'(prod_s2[k][2] >>> FRAC_BITS) + DW'(offset_q);
		end
		v_s3 <= v_s2;
		last_s3 <= last_s2;
	end

	// Stage 4: classify, pick the lone vertex and set up both divisions.
	logic b0, b1, b2, hit_c;
	logic [1:0] li, j0, j1;
	depth_t di, dj0, dj1, clip_e;
	logic [DW-1:0] num_c, den0_c, den1_c;
	pay_t pay_c;
	always_comb begin
		clip_e = DW'(clip_q);
		b0 = dep_s3[0] < clip_e;
		b1 = dep_s3[1] < clip_e;
		b2 = dep_s3[2] < clip_e;
		hit_c = !(b0 == b1 && b0 == b2);
		li = (b0 == b1) ? 2'd2 : (b0 == b2) ? 2'd1 : 2'd0;
		case (li)
			2'd0: begin j0 = 2'd1; j1 = 2'd2; end
			2'd1: begin j0 = 2'd2; j1 = 2'd0; end
			default: begin j0 = 2'd0; j1 = 2'd1; end
		endcase
		di  = dep_s3[li];
		dj0 = dep_s3[j0];
		dj1 = dep_s3[j1];
		num_c  = mag(clip_e - di);
		den0_c = mag(dj0 - di);
		den1_c = mag(dj1 - di);
		pay_c.hit   = hit_c;
		pay_c.last  = last_s3;
		pay_c.full0 = num_c >= den0_c;
		pay_c.full1 = num_c >= den1_c;
		for (int m = 0; m < 3; m++) begin
			pay_c.ai[m]  = v_s3[li][m];
			pay_c.dl0[m] = DLW'(v_s3[j0][m]) - DLW'(v_s3[li][m]);
			pay_c.dl1[m] = DLW'(v_s3[j1][m]) - DLW'(v_s3[li][m]);
		end
	end

	// Divider pipeline: entry 0 is stage 4, each further entry adds one quotient bit.
	logic          vld_sd  [FRAC_BITS+1];
	pay_t          pay_sd  [FRAC_BITS+1];
	logic [DW:0]   r0_sd   [FRAC_BITS+1];
	logic [DW:0]   r1_sd   [FRAC_BITS+1];
	logic [DW-1:0] den0_sd [FRAC_BITS+1];
	logic [DW-1:0] den1_sd [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] q0_sd [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] q1_sd [FRAC_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sd[0] <= 1'b0;
		else vld_sd[0] <= vld_s3;
	end
	always_ff @(posedge clk) begin
		pay_sd[0]  <= pay_c;
		r0_sd[0]   <= {1'b0, num_c};
		r1_sd[0]   <= {1'b0, num_c};
		den0_sd[0] <= den0_c;
		den1_sd[0] <= den1_c;
		q0_sd[0]   <= '0;
		q1_sd[0]   <= '0;
	end

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
		logic [DW:0] t0, t1;
		logic ge0, ge1;
		assign t0  = {r0_sd[k][DW-1:0], 1'b0};
		assign t1  = {r1_sd[k][DW-1:0], 1'b0};
		assign ge0 = t0 >= {1'b0, den0_sd[k]};
		assign ge1 = t1 >= {1'b0, den1_sd[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sd[k+1] <= 1'b0;
			else vld_sd[k+1] <= vld_sd[k];
		end
		always_ff @(posedge clk) begin
			pay_sd[k+1]  <= pay_sd[k];
			den0_sd[k+1] <= den0_sd[k];
			den1_sd[k+1] <= den1_sd[k];
			r0_sd[k+1]   <= ge0 ? t0 - {1'b0, den0_sd[k]} : t0;
			r1_sd[k+1]   <= ge1 ? t1 - {1'b0, den1_sd[k]} : t1;
			q0_sd[k+1]   <= {q0_sd[k][FRAC_BITS-2:0], ge0};
			q1_sd[k+1]   <= {q1_sd[k][FRAC_BITS-2:0], ge1};
		end
	end

	// Multiply stage: edge deltas times the ratio.
	logic qf0, qf1;
	logic [QW-1:0] q0_c, q1_c;
	assign qf0 = pay_sd[FRAC_BITS].full0;
	assign qf1 = pay_sd[FRAC_BITS].full1;
	assign q0_c = qf0 ? QW'(1) << FRAC_BITS : {1'b0, q0_sd[FRAC_BITS]};
	assign q1_c = qf1 ? QW'(1) << FRAC_BITS : {1'b0, q1_sd[FRAC_BITS]};

	logic vld_sm;
	pay_t pay_sm;
	logic signed [PW-1:0] mp0_sm [3];
	logic signed [PW-1:0] mp1_sm [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sm <= 1'b0;
		else vld_sm <= vld_sd[FRAC_BITS];
	end
	// Both operands are widened to the product width before the multiply.
	always_ff @(posedge clk) begin
		pay_sm <= pay_sd[FRAC_BITS];
		for (int m = 0; m < 3; m++) begin
			mp0_sm[m] <= $signed(PW'($signed(pay_sd[FRAC_BITS].dl0[m])))
				* $signed(PW'({1'b0, q0_c}));
			mp1_sm[m] <= $signed(PW'($signed(pay_sd[FRAC_BITS].dl1[m])))
				* $signed(PW'({1'b0, q1_c}));
		end
	end

	// Output stage: add to the lone vertex, saturate, zero when there is no crossing.
	function automatic coord_t interp(input coord_t a, input logic signed [PW-1:0] p);
		logic signed [PW:0] s;
		s = (PW+1)'(a) + (PW+1)'(p >>> FRAC_BITS);
		if (s > (PW+1)'(64'sh7FFF_FFFF)) interp = coord_t'(32'h7FFF_FFFF);
		else if (s < -(PW+1)'(64'sh8000_0000)) interp = coord_t'(32'h8000_0000);
		else interp = coord_t'(s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_sm;
	end
	always_ff @(posedge clk) begin
		hit <= pay_sm.hit;
		last_segment <= pay_sm.last;
		p0_x <= pay_sm.hit ? interp(coord_t'(pay_sm.ai[0]), mp0_sm[0]) : '0;
		p0_y <= pay_sm.hit ? interp(coord_t'(pay_sm.ai[1]), mp0_sm[1]) : '0;
		p0_z <= pay_sm.hit ? interp(coord_t'(pay_sm.ai[2]), mp0_sm[2]) : '0;
		p1_x <= pay_sm.hit ? interp(coord_t'(pay_sm.ai[0]), mp1_sm[0]) : '0;
		p1_y <= pay_sm.hit ? interp(coord_t'(pay_sm.ai[1]), mp1_sm[1]) : '0;
		p1_z <= pay_sm.hit ? interp(coord_t'(pay_sm.ai[2]), mp1_sm[2]) : '0;
	end

	// Every captured request leaves after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ##LAT done) else $error("request lost in pipeline");

	// A crossing always has nonzero divisors.
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sd[0] && pay_sd[0].hit |-> den0_sd[0] != '0 && den1_sd[0] != '0)
		else $error("zero divisor on a crossing");

	// No crossing gives zero points.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> p0_x == '0 && p0_y == '0 && p0_z == '0 && p1_x == '0
		&& p1_y == '0 && p1_z == '0) else $error("points set without a crossing");
endmodule
`default_nettype wire

>>> tb/triangle_plane_slicer_top_test.sv
// Testbench for triangle_plane_slicer_top: drives triangle requests and register
// writes, predicts each slice result in a scoreboard class and compares it.
// Depends on tps_pkg and the block under test.
`default_nettype none
module triangle_plane_slicer_top_test;
	import tps_pkg::*;

	localparam int unsigned FRAC = 16;
	localparam int LATENCY = FRAC + 6;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [31:0] v[3][3];
		logic               last;
	} tri_req_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] p[2][3];
		logic               last;
	} slice_t;

	// Predicts the slice of each triangle and holds the pending slices.
	class slice_board;
		longint signed row_x, row_y, row_z, row_off, clip;
		slice_t pending[$];
		int mismatches;

		function new();
			row_x = 0; row_y = 0; row_z = 64'sd1 << FRAC; row_off = 0; clip = 0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic signed [31:0] val);
			case (idx)
				REG_ROW_X:  row_x = val;
				REG_ROW_Y:  row_y = val;
				REG_ROW_Z:  row_z = val;
				REG_OFFSET: row_off = val;
				REG_CLIP:   clip = val;
				default: ;
			endcase
		endfunction

		// Arithmetic shift right floors for negative values too.
		function longint signed floor_q(longint signed v);
			return v >>> FRAC;
		endfunction

		function void note_request(tri_req_t t);
			slice_t s;
			longint signed dep[3], num, den, q, delta, pt;
			bit below[3];
			int lone, j;
			for (int k = 0; k < 3; k++) begin
				dep[k] = floor_q(row_x * t.v[k][0]) + floor_q(row_y * t.v[k][1])
					+ floor_q(row_z * t.v[k][2]) + row_off;
				below[k] = dep[k] < clip;
			end
			s.hit = 0;
			s.last = t.last;
			for (int k = 0; k < 2; k++)
				for (int m = 0; m < 3; m++)
					s.p[k][m] = 0;
			if (!(below[0] == below[1] && below[0] == below[2])) begin
				s.hit = 1;
				lone = (below[0] == below[1]) ? 2 : (below[0] == below[2]) ? 1 : 0;
				for (int k = 0; k < 2; k++) begin
					j = (lone + k + 1) % 3;
					num = clip - dep[lone];
					if (num < 0) num = -num;
					den = dep[j] - dep[lone];
					if (den < 0) den = -den;
					// Quotient by restoring division, as the hardware does it.
					if (num == 0) q = 0;
					else if (num >= den) q = 64'sd1 << FRAC;
					else begin
						longint signed r;
						r = num; q = 0;
						for (int b = 0; b < FRAC; b++) begin
							r = r << 1; q = q << 1;
							if (r >= den) begin
								r = r - den; q = q | 1;
							end
						end
					end
					for (int m = 0; m < 3; m++) begin
						delta = longint'(t.v[j][m]) - longint'(t.v[lone][m]);
						pt = t.v[lone][m] + floor_q(delta * q);
						if (pt > 64'sd2147483647) pt = 64'sd2147483647;
						if (pt < -64'sd2147483648) pt = -64'sd2147483648;
						s.p[k][m] = pt[31:0];
					end
				end
			end
			pending.insert(pending.size(), s);
		endfunction

		function void check_slice(slice_t got);
			slice_t exp_s;
			bit bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected slice result");
				return;
			end
			exp_s = pending.pop_front();
			bad = (got.hit !== exp_s.hit) || (got.last !== exp_s.last);
			for (int k = 0; k < 2; k++)
				for (int m = 0; m < 3; m++)
					if (got.p[k][m] !== exp_s.p[k][m]) bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("slice mismatch: exp hit=%0b p0=%0d,%0d,%0d p1=%0d,%0d,%0d l=%0b",
						exp_s.hit, exp_s.p[0][0], exp_s.p[0][1], exp_s.p[0][2],
						exp_s.p[1][0], exp_s.p[1][1], exp_s.p[1][2], exp_s.last);
					$display("                got hit=%0b p0=%0d,%0d,%0d p1=%0d,%0d,%0d l=%0b",
						got.hit, got.p[0][0], got.p[0][1], got.p[0][2],
						got.p[1][0], got.p[1][1], got.p[1][2], got.last);
				end
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0, busy, done, hit, last_triangle = 0, last_segment;
	coord_t a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0, c_x = 0, c_y = 0, c_z = 0;
	coord_t p0_x, p0_y, p0_z, p1_x, p1_y, p1_z;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	coord_t cfg_data = 0;
	longint cycles = 0;
	slice_board board;

	triangle_plane_slicer_top #(.FRAC_BITS(FRAC)) uut (.*);

	always #5 clk = ~clk;

	// Count cycles and end the run on a timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Collect every strobed result.
	always @(posedge clk) begin
		slice_t got;
		if (arst_n && done) begin
			got.hit = hit; got.last = last_segment;
			got.p[0][0] = p0_x; got.p[0][1] = p0_y; got.p[0][2] = p0_z;
			got.p[1][0] = p1_x; got.p[1][1] = p1_y; got.p[1][2] = p1_z;
			board.check_slice(got);
		end
	end

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 20)) - 10 <<< 16;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 2000000)) - 1000000;
		endcase
	endfunction

	// A gap drops start first; with no gap start stays high for the next request.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n != 0) begin
			start <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Send one triangle request; start is left high for the caller to drop.
	task automatic send_triangle(tri_req_t t);
		a_x <= t.v[0][0]; a_y <= t.v[0][1]; a_z <= t.v[0][2];
		b_x <= t.v[1][0]; b_y <= t.v[1][1]; b_z <= t.v[1][2];
		c_x <= t.v[2][0]; c_y <= t.v[2][1]; c_z <= t.v[2][2];
		last_triangle <= t.last;
		start <= 1;
		do @(posedge clk); while (busy);
		board.note_request(t);
		@(negedge clk);
	endtask

	// Register write; cfg_valid is left high for the caller to drop.
	task automatic write_reg(cfg_reg_t idx, logic signed [31:0] val);
		cfg_index <= idx; cfg_data <= val; cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic random_triangle(int mode);
		tri_req_t t;
		for (int k = 0; k < 3; k++)
			for (int m = 0; m < 3; m++)
				t.v[k][m] = rand_coord(($urandom_range(0, 7) == 0) ? 0 : mode);
		t.last = $urandom_range(0, 1);
		send_triangle(t);
	endtask

	task automatic set_plane(int setting);
		case (setting)
			0: begin
				write_reg(REG_ROW_X, 0); write_reg(REG_ROW_Y, 0);
				write_reg(REG_ROW_Z, 32'sd65536); write_reg(REG_OFFSET, 0);
				write_reg(REG_CLIP, 0);
			end
			1: begin
				write_reg(REG_ROW_X, 32'sh7fffffff); write_reg(REG_ROW_Y, 32'sh80000000);
				write_reg(REG_ROW_Z, 32'sh7fffffff); write_reg(REG_OFFSET, 32'sh80000000);
				write_reg(REG_CLIP, 32'sh7fffffff);
			end
			2: begin
				write_reg(REG_ROW_X, 32'sh80000000); write_reg(REG_ROW_Y, 32'sh7fffffff);
				write_reg(REG_ROW_Z, 32'sh80000000); write_reg(REG_OFFSET, 32'sh7fffffff);
				write_reg(REG_CLIP, 32'sh80000000);
			end
			default: begin
				write_reg(REG_ROW_X, $signed($urandom_range(0, 131072)) - 65536);
				write_reg(REG_ROW_Y, $signed($urandom_range(0, 131072)) - 65536);
				write_reg(REG_ROW_Z, $urandom_range(0, 3) == 0 ? $urandom
					: $signed($urandom_range(0, 131072)) - 65536);
				write_reg(REG_OFFSET, $signed($urandom_range(0, 200000)) - 100000);
				write_reg(REG_CLIP, $urandom_range(0, 7) == 0 ? $urandom
					: $signed($urandom_range(0, 200000)) - 100000);
			end
		endcase
		cfg_valid <= 0;
	endtask

	initial begin
		tri_req_t t;
		board = new();
		repeat (2) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: plane through the middle, vertex exactly on the plane,
		// all on one side, each vertex as the lone one, coordinate extremes.
		for (int d = 0; d < 12; d++) begin
			for (int k = 0; k < 3; k++)
				for (int m = 0; m < 3; m++)
					t.v[k][m] = (m + k) << 16;
			t.last = d[0];
			case (d)
				0: begin t.v[0][2] = -65536; t.v[1][2] = 65536; t.v[2][2] = 65536; end
				1: begin t.v[1][2] = -65536; t.v[0][2] = 65536; t.v[2][2] = 65536; end
				2: begin t.v[2][2] = -65536; t.v[0][2] = 65536; t.v[1][2] = 65536; end
				3: begin t.v[0][2] = 0; t.v[1][2] = -65536; t.v[2][2] = -65536; end
				4: begin t.v[0][2] = 5; t.v[1][2] = 6; t.v[2][2] = 7; end
				5: begin t.v[0][2] = -5; t.v[1][2] = -6; t.v[2][2] = -7; end
				6: begin
					t.v[0] = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
					t.v[1] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
					t.v[2] = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
				end
				7: begin
					t.v[0] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
					t.v[1] = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
					t.v[2] = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
				end
				8: begin t.v[0][2] = -1; t.v[1][2] = 0; t.v[2][2] = 0; end
				default: begin
					for (int k = 0; k < 3; k++)
						for (int m = 0; m < 3; m++)
							t.v[k][m] = $urandom;
				end
			endcase
			send_triangle(t);
		end
		drain();

		// Random phases over several plane settings, extremes included.
		for (int ph = 0; ph < 10; ph++) begin
			set_plane(ph < 3 ? ph : 3);
			for (int i = 0; i < 150; i++) begin
				random_triangle(ph < 3 ? $urandom_range(0, 2) : $urandom_range(0, 3));
				idle_gap();
				if (i == 75 && ph == 4) drain();
			end
			drain();
		end

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
